[rtl/core/rmv_pkg.sv]
// ----------------------------------------------------------------------------
// rmv_pkg
// shared types and constants for the running mean / variance block
// ----------------------------------------------------------------------------
package rmv_pkg;

  localparam int unsigned CountBitsDefault  = 32;
  localparam int unsigned SampleBitsDefault = 32;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean_value;
    logic [63:0] variance;
    logic [31:0] std_dev;
    logic [31:0] std_dev_of_mean;
    logic        spread_valid;
    logic        saturated;
  } out_item_t;

  // command to the shared divide / square root unit
  typedef enum logic [1:0] {
    AU_DIV  = 2'b01,
    AU_SQRT = 2'b10
  } au_op_e;

  typedef struct packed {
    logic   start;
    au_op_e op;
    logic   neg;
  } au_ctl_t;

endpackage

[rtl/core/running_mean_variance.sv]
// ----------------------------------------------------------------------------
// running_mean_variance
// welford running mean and variance over signed q16.16 samples
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. An add works out the spread only
// once at least two samples are held, an add ignored at full count works out
// the spread alone, and a clear only resets the accumulators: the sequencer
// runs a single shared unit that does a restoring divide or a square root,
// used for the mean update, the variance, variance over count and two roots,
// plus a short partial-product multiplier for the squared-deviation term. The
// result sits in an output register; ready drops while a transaction is being
// worked on or its result has not been taken.
module running_mean_variance
  import rmv_pkg::*;
#(
  parameter int unsigned COUNT_BITS  = CountBitsDefault,
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MDIV  = 10'b0000000010,
    ST_MUPD  = 10'b0000000100,
    ST_MUL   = 10'b0000001000,
    ST_ACC   = 10'b0000010000,
    ST_VDIV  = 10'b0000100000,
    ST_SD    = 10'b0001000000,
    ST_VCDIV = 10'b0010000000,
    ST_SDM   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // accumulators
  logic signed [47:0]    mean_q, mean_d;
  logic [63:0]           ssq_q, ssq_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  // per-transaction scratch
  logic signed [48:0] x32_q, x32_d;
  logic signed [48:0] delta_q, delta_d;
  logic [63:0]        var_q, var_d;
  logic [31:0]        sd_q, sd_d;
  logic               sat_q, sat_d;
  out_item_t          out_q, out_d;
  logic               ovld_q, ovld_d;

  au_ctl_t     au_ctl;
  logic [63:0] au_a, au_b, au_res;
  logic        au_done;
  logic        mul_start, mul_done, mul_clip;
  logic [63:0] mul_res;

  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [48:0]            rest;
  logic [63:0]                   absd, absr;
  logic [64:0]                   ssq_sum;
  logic [COUNT_BITS:0]           cnt_inc;
  logic [47:0]                   mean_rnd;

  rmv_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (au_ctl),
    .opa_i  (au_a),
    .opb_i  (au_b),
    .done_o (au_done),
    .res_o  (au_res)
  );

  rmv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (absd),
    .b_i     (absr),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .clip_o  (mul_clip)
  );

  assign smp     = in_data_i.sample[SAMPLE_BITS-1:0];
  assign rest    = x32_q - 49'(mean_q);
  assign absd    = 64'(delta_q[48] ? -delta_q : delta_q);
  assign absr    = 64'(rest[48] ? -rest : rest);
  assign ssq_sum = {1'b0, ssq_q} + {1'b0, mul_res};
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  // round q16.32 mean to q16.16: add half an lsb
  assign mean_rnd = mean_q + 48'sh8000;

  assign in_ready_o  = (state_q == ST_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    mean_d    = mean_q;
    ssq_d     = ssq_q;
    cnt_d     = cnt_q;
    x32_d     = x32_q;
    delta_d   = delta_q;
    var_d     = var_q;
    sd_d      = sd_q;
    sat_d     = sat_q;
    out_d     = out_q;
    ovld_d    = ovld_q;
    au_ctl    = '{start: 1'b0, op: AU_DIV, neg: 1'b0};
    au_a      = '0;
    au_b      = '0;
    mul_start = 1'b0;

    if (ovld_q && out_ready_i) ovld_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          sat_d = 1'b0;
          var_d = '0;
          sd_d  = '0;
          if (in_data_i.operation == OP_CLEAR) begin
            mean_d  = '0;
            ssq_d   = '0;
            cnt_d   = '0;
            state_d = ST_OUT;
          end else if (cnt_q == CountMax) begin
            sat_d   = 1'b1;
            state_d = (cnt_q >= COUNT_BITS'(2)) ? ST_VDIV : ST_OUT;
            if (cnt_q >= COUNT_BITS'(2)) begin
              au_ctl = '{start: 1'b1, op: AU_DIV, neg: 1'b0};
              au_a   = ssq_q;
              au_b   = 64'(cnt_q - 1'b1);
            end
          end else begin
            x32_d   = 49'(smp) <<< 16;
            delta_d = (49'(smp) <<< 16) - 49'(mean_q);
            // divide magnitude, sign applied at the output (truncation to zero)
            au_ctl  = '{start: 1'b1, op: AU_DIV,
                        neg: ((49'(smp) <<< 16) - 49'(mean_q)) < 0};
            au_a    = 64'(((49'(smp) <<< 16) - 49'(mean_q)) < 0 ?
                          -((49'(smp) <<< 16) - 49'(mean_q)) :
                          ((49'(smp) <<< 16) - 49'(mean_q)));
            au_b    = 64'(cnt_inc);
            state_d = ST_MDIV;
          end
        end
      end
      ST_MDIV: begin
        if (au_done) begin
          mean_d  = mean_q + au_res[47:0];
          cnt_d   = cnt_inc[COUNT_BITS-1:0];
          state_d = ST_MUPD;
        end
      end
      ST_MUPD: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (mul_clip || ssq_sum[64]) begin
          ssq_d = '1;
          sat_d = 1'b1;
        end else begin
          ssq_d = ssq_sum[63:0];
        end
        state_d = (cnt_q >= COUNT_BITS'(2)) ? ST_VDIV : ST_OUT;
        if (cnt_q >= COUNT_BITS'(2)) begin
          au_ctl = '{start: 1'b1, op: AU_DIV, neg: 1'b0};
          au_a   = (mul_clip || ssq_sum[64]) ? '1 : ssq_sum[63:0];
          au_b   = 64'(cnt_q - 1'b1);
        end
      end
      ST_VDIV: begin
        if (au_done) begin
          var_d   = au_res;
          au_ctl  = '{start: 1'b1, op: AU_SQRT, neg: 1'b0};
          au_a    = au_res;
          state_d = ST_SD;
        end
      end
      ST_SD: begin
        if (au_done) begin
          sd_d    = au_res[31:0];
          au_ctl  = '{start: 1'b1, op: AU_DIV, neg: 1'b0};
          au_a    = var_q;
          au_b    = 64'(cnt_q);
          state_d = ST_VCDIV;
        end
      end
      ST_VCDIV: begin
        if (au_done) begin
          au_ctl  = '{start: 1'b1, op: AU_SQRT, neg: 1'b0};
          au_a    = au_res;
          state_d = ST_SDM;
        end
      end
      ST_SDM: begin
        if (au_done) begin
          out_d.std_dev_of_mean = au_res[31:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_d.count        = 32'(cnt_q);
        out_d.mean_value   = mean_rnd[47:16];
        out_d.spread_valid = (cnt_q >= COUNT_BITS'(2));
        out_d.variance     = (cnt_q >= COUNT_BITS'(2)) ? var_q : '0;
        out_d.std_dev      = (cnt_q >= COUNT_BITS'(2)) ? sd_q : '0;
        if (cnt_q < COUNT_BITS'(2)) out_d.std_dev_of_mean = '0;
        out_d.saturated    = sat_q;
        ovld_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mean_q  <= '0;
      ssq_q   <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mean_q  <= mean_d;
      ssq_q   <= ssq_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x32_q   <= x32_d;
    delta_q <= delta_d;
    var_q   <= var_d;
    sd_q    <= sd_d;
    out_q   <= out_d;
  end

endmodule

[rtl/core/rmv_arith.sv]
// ----------------------------------------------------------------------------
// rmv_arith
// shared iterative unit: 64-bit restoring divide and 64-bit integer sqrt
// ----------------------------------------------------------------------------
module rmv_arith
  import rmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  au_ctl_t     ctl_i,
  input  logic [63:0] opa_i,
  input  logic [63:0] opb_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic        busy_q, busy_d;
  au_op_e      op_q, op_d;
  logic        neg_q, neg_d;
  logic [5:0]  step_q, step_d;
  logic [63:0] num_q, num_d;
  logic [63:0] den_q, den_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic        done_q, done_d;

  logic [64:0] rem_sh;
  logic [64:0] trial;
  logic [65:0] sq_rem;
  logic [65:0] sq_try;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    neg_d  = neg_q;
    step_d = step_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    rem_sh = '0;
    trial  = '0;
    sq_rem = '0;
    sq_try = '0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctl_i.op;
      neg_d  = ctl_i.neg;
      step_d = '0;
      num_d  = opa_i;
      den_d  = opb_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      unique case (op_q)
        AU_DIV: begin
          // one quotient bit per cycle
          rem_sh = {rem_q[63:0], num_q[63]};
          trial  = rem_sh - {1'b0, den_q};
          num_d  = {num_q[62:0], 1'b0};
          if (!trial[64]) begin
            rem_d = trial;
            quo_d = {quo_q[62:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            quo_d = {quo_q[62:0], 1'b0};
          end
        end
        default: begin
          // one root bit per cycle, two radicand bits in
          sq_rem = {rem_q[63:0], num_q[63:62]};
          sq_try = sq_rem - {quo_q, 2'b01};
          num_d  = {num_q[61:0], 2'b00};
          if (!sq_try[65]) begin
            rem_d = sq_try[64:0];
            quo_d = {quo_q[62:0], 1'b1};
          end else begin
            rem_d = sq_rem[64:0];
            quo_d = {quo_q[62:0], 1'b0};
          end
        end
      endcase
      step_d = step_q + 6'd1;
      if ((op_q == AU_DIV && step_q == 6'd63) || (op_q != AU_DIV && step_q == 6'd31)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      op_q   <= AU_DIV;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      op_q   <= op_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign res_o  = neg_q ? (~quo_q + 64'd1) : quo_q;

endmodule

[rtl/core/rmv_mul.sv]
// ----------------------------------------------------------------------------
// rmv_mul
// 49x49 product shifted right by 32, built from four 32x32 partial products
// over successive cycles, with clipping to all ones
// ----------------------------------------------------------------------------
module rmv_mul
  import rmv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] res_o,
  output logic        clip_o
);

  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] a_q, a_d, b_q, b_d;
  logic [31:0] ma, mb;
  logic [63:0] prod_q;
  logic [66:0] acc_q, acc_d;
  logic        clip_q, clip_d;

  always_comb begin
    unique case (step_q)
      3'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
      3'd1:    begin ma = a_q[63:32]; mb = b_q[31:0];  end
      3'd2:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
      default: begin ma = a_q[63:32]; mb = b_q[63:32]; end
    endcase
  end

  // product registered, then added into the accumulator
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    clip_d = clip_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      clip_d = 1'b0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      unique case (step_q)
        3'd1:    acc_d = {35'd0, prod_q[63:32]};
        3'd2:    acc_d = acc_q + {3'd0, prod_q};
        3'd3:    acc_d = acc_q + {3'd0, prod_q};
        3'd4: begin
          acc_d = acc_q + {prod_q[34:0], 32'd0};
          if (prod_q[63:32] != 32'd0) clip_d = 1'b1;
        end
        3'd5: begin
          if (acc_q[66:64] != 3'd0) clip_d = 1'b1;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      clip_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      clip_q <= clip_d;
    end
  end

  assign done_o = done_q;
  assign clip_o = clip_q;
  assign res_o  = clip_q ? '1 : acc_q[63:0];

endmodule

[dv/running_mean_variance_tb.sv]
// ----------------------------------------------------------------------------
// running_mean_variance_tb
// self-checking bench for the welford running mean / variance block
// ----------------------------------------------------------------------------
// A directed table covers clears, first samples, the sample extremes and
// sum-of-squares clipping. It is followed by random adds with occasional
// clears. Every accepted transaction is predicted in the bench, and each
// result is compared field by field against the oldest expectation, typed
// by hand for some directed rows. Both sides idle at random, and once the
// output side holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module running_mean_variance_tb;
  import rmv_pkg::*;

  localparam int unsigned NumRandom     = 450;
  localparam int unsigned HoldOffCycles = 3000;
  localparam int unsigned DrainCycles   = 400;
  localparam longint      LimitCycles   = 1_000_000;
  localparam logic [63:0] CountFull     = 64'hFFFF_FFFF;

  typedef struct {
    op_e         op;
    logic [31:0] sample;
    bit          typed;   // expected result written out by hand
    out_item_t   result;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // model state of the accumulators
  longint      mean_q32;
  logic [63:0] sum_sq;
  logic [63:0] n_samples;

  out_item_t   pending_results[$];
  stim_row_t   directed[$];
  int unsigned error_count = 0;

  running_mean_variance dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin
    repeat (LimitCycles) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    error_count++;
  endtask

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // advance the accumulators by one transaction and return its result
  function automatic out_item_t welford_update(input in_item_t it);
    out_item_t   res;
    longint      x32;
    longint      delta;
    longint      rest;
    longint      rounded;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] term;
    logic [127:0] prod;
    logic [63:0] var_q;
    bit          sat;
    res = '0;
    sat = 1'b0;
    if (op_e'(it.operation) == OP_CLEAR) begin
      mean_q32  = 0;
      sum_sq    = '0;
      n_samples = '0;
    end else if (n_samples >= CountFull) begin
      sat = 1'b1;
    end else begin
      x32      = longint'($signed(it.sample)) * 65536;
      delta    = x32 - mean_q32;
      mean_q32 = mean_q32 + delta / longint'(n_samples + 1);
      rest     = x32 - mean_q32;
      a        = delta < 0 ? -delta : delta;
      b        = rest < 0 ? -rest : rest;
      prod     = {64'd0, a} * {64'd0, b};
      if (prod[127:96] != '0) begin
        term = '1;
        sat  = 1'b1;
      end else begin
        term = prod[95:32];
      end
      // clip the sum of squares instead of wrapping
      if (sum_sq > ~term) begin
        sum_sq = '1;
        sat    = 1'b1;
      end else begin
        sum_sq = sum_sq + term;
      end
      n_samples = n_samples + 1;
    end
    rounded        = (mean_q32 + 32768) >>> 16;
    res.count      = n_samples[31:0];
    res.mean_value = rounded[31:0];
    res.saturated  = sat;
    if (n_samples >= 2) begin
      var_q               = sum_sq / (n_samples - 1);
      res.variance        = var_q;
      res.std_dev         = floor_sqrt(var_q);
      res.std_dev_of_mean = floor_sqrt(var_q / n_samples);
      res.spread_valid    = 1'b1;
    end
    return res;
  endfunction

  function automatic stim_row_t row(input op_e op, input logic [31:0] sample);
    stim_row_t r;
    r.op     = op;
    r.sample = sample;
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input op_e op, input logic [31:0] sample,
                                          input logic [31:0] cnt, input logic [31:0] mean,
                                          input logic spread);
    stim_row_t r;
    r = row(op, sample);
    r.typed               = 1'b1;
    r.result.count        = cnt;
    r.result.mean_value   = mean;
    r.result.spread_valid = spread;
    return r;
  endfunction

  // offer one transaction; idle first for the drawn gap, then hold until taken
  task automatic offer(input op_e op, input logic [31:0] sample, input int unsigned gap,
                       input bit typed, input out_item_t typed_result);
    in_item_t  it;
    out_item_t predicted;
    it.operation = op;
    it.sample    = sample;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = welford_update(it);
    pending_results.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  // random sample: full range, small values, or a cluster around a base
  function automatic logic [31:0] draw_sample(input logic [31:0] base);
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 'h3FFFF)) - 'h20000);
      default: return base + 32'($signed($urandom_range(0, 'hFFFFF)) - 'h80000);
    endcase
  endfunction

  // stimulus
  initial begin
    logic [31:0] base;
    bit          idle_on;
    mean_q32  = 0;
    sum_sq    = '0;
    n_samples = '0;

    // clears, first samples, extremes, and alternating extremes to clip the sum
    directed.push_back(typed_row(OP_CLEAR, 32'h1234_5678, '0, '0, 1'b0));
    directed.push_back(typed_row(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 1'b0));
    directed.push_back(row(OP_ADD, 32'h8000_0000));
    directed.push_back(row(OP_ADD, 32'h7FFF_FFFF));
    directed.push_back(row(OP_ADD, 32'h8000_0000));
    directed.push_back(row(OP_ADD, 32'h7FFF_FFFF));
    directed.push_back(row(OP_ADD, 32'h8000_0000));
    directed.push_back(row(OP_ADD, 32'h0000_0000));
    directed.push_back(typed_row(OP_CLEAR, 32'hFFFF_FFFF, '0, '0, 1'b0));
    directed.push_back(typed_row(OP_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 1'b0));
    directed.push_back(row(OP_ADD, 32'h0000_0000));
    directed.push_back(row(OP_ADD, 32'h0000_0001));
    directed.push_back(row(OP_ADD, 32'hFFFF_FFFF));
    directed.push_back(row(OP_ADD, 32'h0001_0000));
    directed.push_back(row(OP_ADD, 32'h5555_AAAA));
    directed.push_back(row(OP_ADD, 32'hAAAA_5555));
    directed.push_back(typed_row(OP_CLEAR, 32'h0, '0, '0, 1'b0));
    directed.push_back(typed_row(OP_ADD, 32'h0, 32'd1, '0, 1'b0));
    directed.push_back(typed_row(OP_ADD, 32'h0, 32'd2, '0, 1'b1));
    directed.push_back(row(OP_ADD, 32'hFFFF_0000));
    directed.push_back(row(OP_ADD, 32'h0002_8000));

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      offer(directed[i].op, directed[i].sample, $urandom_range(0, 17),
            directed[i].typed, directed[i].result);
    end

    base    = $urandom();
    idle_on = 1'b1;
    for (int unsigned i = 0; i < NumRandom; i++) begin
      // alternate stretches with and without idle gaps
      if (i % 40 == 0) idle_on = !idle_on;
      if ($urandom_range(0, 24) == 0) begin
        offer(OP_CLEAR, $urandom(), idle_on ? $urandom_range(0, 17) : 0, 1'b0, '0);
        base = $urandom();
      end else begin
        offer(OP_ADD, draw_sample(base), idle_on ? $urandom_range(0, 17) : 0, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, field-by-field compare
  initial begin
    out_item_t   want;
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 60) stall = HoldOffCycles;
      else if ((taken / 50) % 2 == 1) stall = 0;
      else stall = $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      if (pending_results.size() == 0) begin
        $display("result transaction with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.count != want.count)
          report("count", out_data_o.count, want.count);
        if (out_data_o.mean_value != want.mean_value)
          report("mean_value", out_data_o.mean_value, want.mean_value);
        if (out_data_o.variance != want.variance)
          report("variance", out_data_o.variance, want.variance);
        if (out_data_o.std_dev != want.std_dev)
          report("std_dev", out_data_o.std_dev, want.std_dev);
        if (out_data_o.std_dev_of_mean != want.std_dev_of_mean)
          report("std_dev_of_mean", out_data_o.std_dev_of_mean, want.std_dev_of_mean);
        if (out_data_o.spread_valid != want.spread_valid)
          report("spread_valid", out_data_o.spread_valid, want.spread_valid);
        if (out_data_o.saturated != want.saturated)
          report("saturated", out_data_o.saturated, want.saturated);
      end
      @(negedge clk_i);
    end
  end

endmodule

[sim.f]
rtl/core/rmv_pkg.sv
rtl/core/rmv_arith.sv
rtl/core/rmv_mul.sv
rtl/core/running_mean_variance.sv
dv/running_mean_variance_tb.sv
